// ===== rtl/core/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg
// Shared types and constants for the positional list core.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int Capacity = 64;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CountW   = $clog2(Capacity + 1);
  localparam int DataW    = 32;
  localparam int ActW     = 4;
  localparam int PosW     = 7;
  localparam int StatW    = 2;

  typedef enum logic [ActW-1:0] {
    ACT_PUSH_FRONT = 4'd0,
    ACT_PUSH_BACK  = 4'd1,
    ACT_POP_FRONT  = 4'd2,
    ACT_POP_BACK   = 4'd3,
    ACT_INSERT     = 4'd4,
    ACT_ERASE      = 4'd5,
    ACT_READ       = 4'd6,
    ACT_WRITE      = 4'd7,
    ACT_FRONT      = 4'd8,
    ACT_BACK       = 4'd9,
    ACT_REVERSE    = 4'd10,
    ACT_CLEAR      = 4'd11
  } action_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2,
    CELL_WRITE = 2'd3
  } cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_e         op;
    logic [IdxW-1:0]  pos;
    logic [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/plc_cell.sv =====
// ----------------------------------------------------------------------------
// plc_cell
// One storage slot of the list row: holds a word, shifts it toward either
// neighbor, or loads the broadcast word; drives its word on a read match.
// ----------------------------------------------------------------------------
module plc_cell (
  input  logic                          clk_i,
  input  logic [plc_pkg::IdxW-1:0]      idx_i,
  input  plc_pkg::cell_ctrl_t           ctrl_i,
  input  logic [plc_pkg::DataW-1:0]     left_i,
  input  logic [plc_pkg::DataW-1:0]     right_i,
  output logic [plc_pkg::DataW-1:0]     data_o,
  output logic [plc_pkg::DataW-1:0]     rd_o
);

  logic [plc_pkg::DataW-1:0] data_q, data_d;
  logic                      hit, above;

  assign hit   = (idx_i == ctrl_i.pos);
  assign above = (idx_i > ctrl_i.pos);

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      plc_pkg::CELL_HOLD: data_d = data_q;
      plc_pkg::CELL_OPEN: begin
        if (above) begin
          data_d = left_i;
        end else if (hit) begin
          data_d = ctrl_i.value;
        end
      end
      plc_pkg::CELL_CLOSE: begin
        if (above || hit) begin
          data_d = right_i;
        end
      end
      plc_pkg::CELL_WRITE: begin
        if (hit) begin
          data_d = ctrl_i.value;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = hit ? data_q : '0;

endmodule

// ===== rtl/core/positional_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Ordered list of signed words kept in a row of shifting cells.
// Each word is taken in idle, applied in the execute state in which the whole
// cell row shifts, then flagged by registered done_o; none is taken while busy.
// Reverse flips an orientation bit, so it costs no more than any other word.
// Reset clears count, orientation and the strobe; cell contents stay as is.
// ----------------------------------------------------------------------------
module positional_list_engine_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [plc_pkg::ActW-1:0]      action_i,
  input  logic [plc_pkg::PosW-1:0]      position_i,
  input  logic signed [plc_pkg::DataW-1:0] value_i,
  output logic                          done_o,
  output logic signed [plc_pkg::DataW-1:0] result_value_o,
  output logic [plc_pkg::StatW-1:0]     status_o,
  output logic [plc_pkg::CountW-1:0]    element_count_o,
  output logic                          is_empty_o
);

  localparam int N = plc_pkg::Capacity;

  plc_pkg::state_e state_q, state_d;

  logic [plc_pkg::ActW-1:0]   act_q;
  logic [plc_pkg::PosW-1:0]   pos_q;
  logic [plc_pkg::DataW-1:0]  val_q;
  logic [plc_pkg::CountW-1:0] count_q, count_d;
  logic                       rev_q, rev_d;
  logic                       done_q;
  logic [plc_pkg::DataW-1:0]  res_q;
  logic [plc_pkg::StatW-1:0]  stat_q;

  logic                       accept, exec;

  // decode results
  plc_pkg::cell_op_e          op;
  plc_pkg::status_e           stat;
  logic [plc_pkg::PosW-1:0]   key;
  logic                       gap_map;
  logic                       has_res;
  logic [plc_pkg::PosW-1:0]   phys;
  logic                       full, empty;

  plc_pkg::cell_ctrl_t        ctrl;
  logic [plc_pkg::DataW-1:0]  cell_data [N];
  logic [plc_pkg::DataW-1:0]  cell_rd   [N];
  logic [plc_pkg::DataW-1:0]  rd_all;

  // ---------------- FSM ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plc_pkg::ST_IDLE: if (start) state_d = plc_pkg::ST_EXEC;
      plc_pkg::ST_EXEC: state_d = plc_pkg::ST_IDLE;
      default:          state_d = plc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state_q == plc_pkg::ST_EXEC);
    exec = (state_q == plc_pkg::ST_EXEC);
  end

  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= action_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  // ---------------- decode ----------------
  assign full  = (count_q >= plc_pkg::CountW'(N));
  assign empty = (count_q == '0);

  always_comb begin
    op      = plc_pkg::CELL_HOLD;
    stat    = plc_pkg::STAT_OK;
    key     = pos_q;
    gap_map = 1'b0;
    has_res = 1'b0;
    count_d = count_q;
    rev_d   = rev_q;
    unique case (plc_pkg::action_e'(act_q))
      plc_pkg::ACT_PUSH_FRONT, plc_pkg::ACT_PUSH_BACK: begin
        gap_map = 1'b1;
        key     = (plc_pkg::action_e'(act_q) == plc_pkg::ACT_PUSH_FRONT) ? '0 : count_q;
        if (full) begin
          stat = plc_pkg::STAT_FULL;
        end else begin
          op      = plc_pkg::CELL_OPEN;
          count_d = count_q + 1'b1;
        end
      end
      plc_pkg::ACT_POP_FRONT, plc_pkg::ACT_POP_BACK: begin
        key = (plc_pkg::action_e'(act_q) == plc_pkg::ACT_POP_FRONT) ? '0 : count_q - 1'b1;
        if (empty) begin
          stat = plc_pkg::STAT_EMPTY;
        end else begin
          op      = plc_pkg::CELL_CLOSE;
          has_res = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      plc_pkg::ACT_INSERT: begin
        gap_map = 1'b1;
        priority if (pos_q > count_q) begin
          stat = plc_pkg::STAT_RANGE;
        end else if (full) begin
          stat = plc_pkg::STAT_FULL;
        end else begin
          op      = plc_pkg::CELL_OPEN;
          count_d = count_q + 1'b1;
        end
      end
      plc_pkg::ACT_ERASE, plc_pkg::ACT_READ, plc_pkg::ACT_WRITE: begin
        if (pos_q >= count_q) begin
          stat = plc_pkg::STAT_RANGE;
        end else begin
          unique case (plc_pkg::action_e'(act_q))
            plc_pkg::ACT_ERASE: begin
              op      = plc_pkg::CELL_CLOSE;
              has_res = 1'b1;
              count_d = count_q - 1'b1;
            end
            plc_pkg::ACT_READ: has_res = 1'b1;
            default:           op = plc_pkg::CELL_WRITE;
          endcase
        end
      end
      plc_pkg::ACT_FRONT, plc_pkg::ACT_BACK: begin
        key = (plc_pkg::action_e'(act_q) == plc_pkg::ACT_FRONT) ? '0 : count_q - 1'b1;
        if (empty) begin
          stat = plc_pkg::STAT_EMPTY;
        end else begin
          has_res = 1'b1;
        end
      end
      plc_pkg::ACT_REVERSE: rev_d = !rev_q;
      plc_pkg::ACT_CLEAR:   count_d = '0;
      default: ;
    endcase
  end

  // logical to physical slot; when reversed, a gap position maps to n-k, an element to n-1-k
  always_comb begin
    if (!rev_q) begin
      phys = key;
    end else if (gap_map) begin
      phys = count_q - key;
    end else begin
      phys = count_q - key - 1'b1;
    end
  end

  always_comb begin
    ctrl.op    = exec ? op : plc_pkg::CELL_HOLD;
    ctrl.pos   = phys[plc_pkg::IdxW-1:0];
    ctrl.value = val_q;
  end

  // ---------------- cell row ----------------
  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [plc_pkg::DataW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    plc_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (plc_pkg::IdxW'(g)),
      .ctrl_i  (ctrl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  always_comb begin
    rd_all = '0;
    for (int i = 0; i < N; i++) begin
      rd_all = rd_all | cell_rd[i];
    end
  end

  // ---------------- state and result ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rev_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= exec;
      if (exec) begin
        count_q <= count_d;
        rev_q   <= rev_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      res_q  <= has_res ? rd_all : '0;
      stat_q <= stat;
    end
  end

  assign done_o          = done_q;
  assign result_value_o  = res_q;
  assign status_o        = stat_q;
  assign element_count_o = count_q;
  assign is_empty_o      = (count_q == '0);

  // ---------------- assertions ----------------
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted word did not start execution");

  a_exec_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (done_o && !busy))
    else $error("execute cycle not followed by a single done strobe");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (element_count_o <= plc_pkg::CountW'(N)))
    else $error("element count beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != plc_pkg::STAT_OK) |-> $stable(element_count_o))
    else $error("failed operation changed the count");

endmodule
